@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the matcher.
// Depends on nothing; the including scope supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/wwmpm_pkg.sv @@
// Shared types, constants and helpers of the whole-word multi-pattern matcher.
// Depends on nothing; every module of the block imports it.
package wwmpm_pkg;

   localparam int POS_W  = 31;
   localparam int SLOT_W = 4;
   localparam int OFS_W  = 5;
   localparam int BYTE_W = 8;
   localparam int OP_W   = 2;

   localparam logic [POS_W-1:0] POS_MAX = 31'h7FFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_TEXT    = 2'd0,
      OP_LOAD    = 2'd1,
      OP_DISABLE = 2'd2
   } wwmpm_op_type;

   // Command broadcast from the top level to every slot cell.
   typedef struct packed {
      logic              text;        // text item accepted
      logic              load;        // in-range pattern load accepted
      logic              dis;         // slot disable accepted
      logic              last;        // is_last of the current payload
      logic [BYTE_W-1:0] byte_value;  // current payload byte
      logic [OFS_W-1:0]  offset;      // load offset
      logic [POS_W-1:0]  stop;        // end position of a match ending here
   } wwmpm_cmd_type;

   // Per-cell status toward the top level.
   typedef struct packed {
      logic pend;  // a match waits for its following byte
      logic fin;   // a whole-word match ends on this byte and last is set
   } wwmpm_cell_stat_type;

   function automatic logic is_word_byte(input logic [BYTE_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

@@ hdl/whole_word_multi_pattern_matcher_top.sv @@
// Top level of the whole-word multi-pattern matcher: slot cells and result serializer.
// Depends on wwmpm_pkg, wwmpm_cell and wwmpm_serializer.
//
// Usage:
//   The req channel carries one item per handshake: a text byte (OP_TEXT),
//   a pattern byte load (OP_LOAD, is_last sets the length) or a slot disable
//   (OP_DISABLE). The rsp channel carries one match per transfer: slot, start and
//   stop (one past the last byte); last_of_run marks the final match caused
//   by one req item.
//   Every slot cell compares its pattern against its own aligned copy of the
//   text window in the same cycle, so req takes one item per cycle unless stalled.
//   A match is confirmed by the next text byte, or at once by is_last. The
//   results of an item are held in the serializer and shown on rsp from its
//   output register; further results of the same item follow one per cycle
//   while rsp is not stalled, so the result stage stays busy until the last one goes.
//   Items that cause no result (loads, disables, most text bytes) are never
//   stalled. A text item that causes results is stalled only while the
//   previous item's results are still being handed out.
//   When the receiver stalls rsp, the shown result holds and the backlog
//   waits; req keeps flowing until an item with new results arrives.
//   Reset (synchronous, active high) disables every slot and starts a new
//   text at position zero; no clearing pass is needed. Pattern bytes are
//   undefined until loaded.
module whole_word_multi_pattern_matcher_top import wwmpm_pkg::*; #(
   parameter int MAX_WORDS = 16,
   parameter int MAX_LEN   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_op,
   input  logic [BYTE_W-1:0]  req_byte_value,
   input  logic               req_is_last,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [OFS_W-1:0]   req_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SLOT_W-1:0]  rsp_match_slot,
   output logic [POS_W-1:0]   rsp_start_pos,
   output logic [POS_W-1:0]   rsp_stop_pos,
   output logic               rsp_last_of_run
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int WIN_W = MAX_LEN * BYTE_W;

   // text position and window, newest byte in the low bits
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [WIN_W-1:0] win_ff, win_in;

   logic [POS_W-1:0] stop;
   logic [WIN_W-1:0] rev;
   logic [WIN_W-1:0] realign;
   logic [LEN_W-1:0] sh;

   logic is_text;
   logic is_load;
   logic is_dis;
   logic ofs_ok;
   logic has_res;
   logic accept;
   logic ser_free;

   wwmpm_cmd_type        cmd;
   wwmpm_cell_stat_type  stat [MAX_WORDS];
   logic [MAX_WORDS-1:0] cell_sel;
   logic [MAX_WORDS-1:0] conf_cand;
   logic [MAX_WORDS-1:0] fin_cand;
   logic [MAX_WORDS*LEN_W-1:0] lens;

   // Saturate the end position at the top of the range.
   assign stop = (pos_ff != POS_MAX) ? pos_ff + POS_W'(1) : POS_MAX;

   assign is_text = (req_op == OP_TEXT);
   assign is_load = (req_op == OP_LOAD);
   assign is_dis  = (req_op == OP_DISABLE);
   assign ofs_ok  = (int'(req_offset) < MAX_LEN);

   // Stall only a text item with results while the serializer still drains.
   assign has_res   = is_text && ((|conf_cand) || (|fin_cand));
   assign req_stall = has_res && !ser_free;
   assign accept    = req_valid && !req_stall;

   assign cmd.text       = accept && is_text;
   assign cmd.load       = accept && is_load && ofs_ok;
   assign cmd.dis        = accept && is_dis;
   assign cmd.last       = req_is_last;
   assign cmd.byte_value = req_byte_value;
   assign cmd.offset     = req_offset;
   assign cmd.stop       = stop;

   // Realign the window for a newly set length L = offset + 1:
   // cell byte j takes window byte L-1-j.
   always_comb begin
      for (int j = 0; j < MAX_LEN; j++) begin
         rev[j*BYTE_W +: BYTE_W] = win_ff[(MAX_LEN-1-j)*BYTE_W +: BYTE_W];
      end
      sh      = LEN_W'(MAX_LEN - 1) - LEN_W'(req_offset);
      realign = rev >> {sh, 3'b000};
   end

   generate
      for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
         assign cell_sel[i] = (int'(req_slot) == i);

         wwmpm_cell #(
            .MAX_LEN (MAX_LEN)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .cmd     (cmd),
            .sel     (cell_sel[i]),
            .realign (realign),
            .stat    (stat[i]),
            .len_out (lens[i*LEN_W +: LEN_W])
         );

         // pending match confirmed when the following byte is not alphanumeric
         assign conf_cand[i] = stat[i].pend && !is_word_byte(req_byte_value);
         assign fin_cand[i]  = stat[i].fin;
      end
   endgenerate

   wwmpm_serializer #(
      .MAX_WORDS (MAX_WORDS),
      .MAX_LEN   (MAX_LEN)
   ) u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load            (accept && has_res),
      .conf_mask       (conf_cand),
      .fin_mask        (fin_cand),
      .conf_stop       (pos_ff),
      .fin_stop        (stop),
      .lens            (lens),
      .free            (ser_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_slot  (rsp_match_slot),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_stop_pos    (rsp_stop_pos),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Advance position and window on text; drop both at end of text.
   always_comb begin
      pos_in = pos_ff;
      win_in = win_ff;
      if (cmd.text) begin
         if (req_is_last) begin
            pos_in = '0;
            win_in = '0;
         end else begin
            pos_in = stop;
            win_in = (win_ff << BYTE_W) | WIN_W'(req_byte_value);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         win_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         win_ff <= win_in;
      end
   end

endmodule

@@ hdl/wwmpm_cell.sv @@
// One pattern slot: pattern bytes, length, aligned text window and match state.
// Depends on wwmpm_pkg.
module wwmpm_cell import wwmpm_pkg::*; #(
   parameter int MAX_LEN = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wwmpm_cmd_type                    cmd,
   input  logic                             sel,
   input  logic [MAX_LEN*BYTE_W-1:0]        realign,
   output wwmpm_cell_stat_type              stat,
   output logic [$clog2(MAX_LEN+1)-1:0]     len_out
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int WIN_W = MAX_LEN * BYTE_W;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic              pend_ff, pend_in;
   logic [POS_W-1:0]  nas_ff, nas_in;
   logic [WIN_W-1:0]  wa_ff, wa_in;
   logic [BYTE_W-1:0] pat_ff [MAX_LEN];

   logic [WIN_W-1:0]   wa_up;
   logic [WIN_W-1:0]   wa_sh;
   logic [MAX_LEN-1:0] eq;
   logic [POS_W-1:0]   start;
   logic               hit;
   logic               keep;

   // wa_ff[j] holds the text byte that lines up with pattern byte j once the
   // next byte arrives: shift toward j = 0, new byte enters at len-1.
   always_comb begin
      wa_up = wa_ff >> BYTE_W;
      for (int j = 0; j < MAX_LEN; j++) begin
         if (j + 1 >= int'(len_ff)) begin
            wa_sh[j*BYTE_W +: BYTE_W] = cmd.byte_value;
         end else begin
            wa_sh[j*BYTE_W +: BYTE_W] = wa_up[j*BYTE_W +: BYTE_W];
         end
         eq[j] = (j >= int'(len_ff)) || (pat_ff[j] == wa_sh[j*BYTE_W +: BYTE_W]);
      end
      start = cmd.stop - POS_W'(len_ff);
      hit   = (len_ff != '0) && (cmd.stop >= POS_W'(len_ff)) && (start >= nas_ff) && (&eq);
      // byte before the match is the oldest aligned byte before the shift
      keep  = hit && ((start == '0) || !is_word_byte(wa_ff[BYTE_W-1:0]));
   end

   always_comb begin
      len_in  = len_ff;
      pend_in = pend_ff;
      nas_in  = nas_ff;
      wa_in   = wa_ff;
      if (cmd.text) begin
         pend_in = keep && !cmd.last;
         if (cmd.last) begin
            nas_in = '0;
            wa_in  = '0;
         end else begin
            wa_in = wa_sh;
            if (hit) begin
               nas_in = cmd.stop;
            end
         end
      end else if (sel && cmd.load && cmd.last) begin
         len_in  = LEN_W'(cmd.offset) + LEN_W'(1);
         pend_in = 1'b0;
         wa_in   = realign;
      end else if (sel && cmd.dis) begin
         len_in  = '0;
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         pend_ff <= 1'b0;
         nas_ff  <= '0;
      end else begin
         len_ff  <= len_in;
         pend_ff <= pend_in;
         nas_ff  <= nas_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff <= wa_in;
      for (int j = 0; j < MAX_LEN; j++) begin
         if (sel && cmd.load && (int'(cmd.offset) == j)) begin
            pat_ff[j] <= cmd.byte_value;
         end
      end
   end

   assign stat.pend = pend_ff;
   assign stat.fin  = keep && cmd.last;
   assign len_out   = len_ff;

endmodule

@@ hdl/wwmpm_serializer.sv @@
// Holds the results of one text item and hands them out one per cycle while rsp is not stalled.
// Depends on wwmpm_pkg.
module wwmpm_serializer import wwmpm_pkg::*; #(
   parameter int MAX_WORDS = 16,
   parameter int MAX_LEN   = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  logic [MAX_WORDS-1:0]                     conf_mask,
   input  logic [MAX_WORDS-1:0]                     fin_mask,
   input  logic [POS_W-1:0]                         conf_stop,
   input  logic [POS_W-1:0]                         fin_stop,
   input  logic [MAX_WORDS*$clog2(MAX_LEN+1)-1:0]   lens,
   output logic                                     free,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [SLOT_W-1:0]                        rsp_match_slot,
   output logic [POS_W-1:0]                         rsp_start_pos,
   output logic [POS_W-1:0]                         rsp_stop_pos,
   output logic                                     rsp_last_of_run
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);

   logic [MAX_WORDS-1:0] conf_ff, conf_in;
   logic [MAX_WORDS-1:0] fin_ff, fin_in;
   logic [POS_W-1:0]     cstop_ff, cstop_in;
   logic [POS_W-1:0]     fstop_ff, fstop_in;
   logic [LEN_W-1:0]     len_ff [MAX_WORDS];

   logic                 valid_ff, valid_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [POS_W-1:0]     start_ff, start_in;
   logic [POS_W-1:0]     stop_ff, stop_in;
   logic                 last_ff, last_in;

   logic                 pick_conf;
   logic [MAX_WORDS-1:0] src;
   logic [MAX_WORDS-1:0] one;
   logic [MAX_WORDS-1:0] conf_nx;
   logic [MAX_WORDS-1:0] fin_nx;
   logic [SLOT_W-1:0]    sel_slot;
   logic [LEN_W-1:0]     sel_len;
   logic [POS_W-1:0]     sel_stop;
   logic                 have;
   logic                 move;
   logic                 run_end;

   // Confirmed matches go first, then last-of-text matches, each lowest slot first.
   always_comb begin
      pick_conf = |conf_ff;
      src       = pick_conf ? conf_ff : fin_ff;
      one       = src & ~(src - MAX_WORDS'(1));
      sel_slot  = '0;
      sel_len   = '0;
      for (int i = 0; i < MAX_WORDS; i++) begin
         if (one[i]) begin
            sel_slot = SLOT_W'(i);
            sel_len  = len_ff[i];
         end
      end
      sel_stop = pick_conf ? cstop_ff : fstop_ff;
      conf_nx  = pick_conf ? (conf_ff & ~one) : conf_ff;
      fin_nx   = pick_conf ? fin_ff : (fin_ff & ~one);
      have     = pick_conf || (|fin_ff);
      move     = have && (!valid_ff || !rsp_stall);
      run_end  = (conf_nx == '0) && (fin_nx == '0);
      free     = !have || (move && run_end);
   end

   always_comb begin
      conf_in  = conf_ff;
      fin_in   = fin_ff;
      cstop_in = cstop_ff;
      fstop_in = fstop_ff;
      if (load) begin
         conf_in  = conf_mask;
         fin_in   = fin_mask;
         cstop_in = conf_stop;
         fstop_in = fin_stop;
      end else if (move) begin
         conf_in = conf_nx;
         fin_in  = fin_nx;
      end

      valid_in = valid_ff;
      slot_in  = slot_ff;
      start_in = start_ff;
      stop_in  = stop_ff;
      last_in  = last_ff;
      if (move) begin
         valid_in = 1'b1;
         slot_in  = sel_slot;
         start_in = sel_stop - POS_W'(sel_len);
         stop_in  = sel_stop;
         last_in  = run_end;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_ff  <= '0;
         fin_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         conf_ff  <= conf_in;
         fin_ff   <= fin_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cstop_ff <= cstop_in;
      fstop_ff <= fstop_in;
      slot_ff  <= slot_in;
      start_ff <= start_in;
      stop_ff  <= stop_in;
      last_ff  <= last_in;
      for (int i = 0; i < MAX_WORDS; i++) begin
         if (load) begin
            len_ff[i] <= lens[i*LEN_W +: LEN_W];
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_match_slot  = slot_ff;
   assign rsp_start_pos   = start_ff;
   assign rsp_stop_pos    = stop_ff;
   assign rsp_last_of_run = last_ff;

endmodule

@@ hdl/wwmpm_checker.sv @@
// Port-level checks of the matcher, bound to the top level.
// Depends on wwmpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wwmpm_checker import wwmpm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [OP_W-1:0]   req_op,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [POS_W-1:0]  rsp_start_pos,
   input logic [POS_W-1:0]  rsp_stop_pos,
   input logic              rsp_last_of_run
);

   // a stalled result holds
   `CHK_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_start_pos) && $stable(rsp_stop_pos), "stalled result changed")

   // reset empties the result stage
   `CHK_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result shown right after reset")

   // every match covers at least one byte
   `CHK_ASSERT(a_span, rsp_valid |-> (rsp_start_pos < rsp_stop_pos), "empty or reversed span")

   // loads and disables never wait
   `CHK_ASSERT(a_ctrl_no_stall, req_valid && (req_op != OP_TEXT) |-> !req_stall, "control item stalled")

   // the results of one item come back to back
   `CHK_ASSERT(a_run_gapless, rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid, "gap inside a run")

endmodule

bind whole_word_multi_pattern_matcher_top wwmpm_checker u_wwmpm_checker (.*);
